[sv/mpwm_pkg.sv]
// ----------------------------------------------------------------------------
// Motor PWM ramp package
// Shared constants and codes for the soft-start motor drive.
// ----------------------------------------------------------------------------
`default_nettype none

package mpwm_pkg;

	localparam int SPEED_FRAC_BITS_DEF = 8;
	localparam int DUTY_BITS_DEF       = 8;
	localparam int CFG_DATA_W          = 16;
	localparam int CFG_IDX_W           = 2;
	localparam int TICK_W              = 16;
	localparam int RAMP_STEP_RST       = 10;
	localparam logic [TICK_W-1:0] RAMP_INTERVAL_RST = TICK_W'(10);

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_REV  = 2'd2
	} dir_t;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_SPEED = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PWM_MAX       = 2'd0,
		CFG_RAMP_STEP     = 2'd1,
		CFG_REV_THRESHOLD = 2'd2,
		CFG_RAMP_INTERVAL = 2'd3
	} cfg_idx_t;

endpackage

`default_nettype wire

[sv/mpwm_if.sv]
// ----------------------------------------------------------------------------
// Motor PWM ramp channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpwm_cmd_if #(
	parameter int SPEED_W = 10
);
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [SPEED_W-1:0] speed;

	modport source (output valid, output opcode, output speed, input ready);
	modport sink   (input valid, input opcode, input speed, output ready);
endinterface

interface mpwm_res_if #(
	parameter int DUTY_W = 8
);
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] pwm_duty;
	logic              reverse_pin;
	logic [1:0]        direction;
	logic              settled;
	logic              status;

	modport source (output valid, output pwm_duty, output reverse_pin, output direction,
		output settled, output status, input ready);
	modport sink   (input valid, input pwm_duty, input reverse_pin, input direction,
		input settled, input status, output ready);
endinterface

`default_nettype wire

[sv/motor_pwm_ramp_with_reversal_core.sv]
// ----------------------------------------------------------------------------
// Motor PWM ramp with reversal interlock
// Slew-rate limited duty control with a direction interlock for a motor drive.
// ----------------------------------------------------------------------------
// Commands are registered in an input stage; drive state and result word are
// registered when the output slot is free. Throughput is one word per cycle
// while res.ready holds, via a single registered stage and one duty multiplier.
// Reset clears the drive state and loads the register defaults; the block
// accepts words as soon as reset is released.
`default_nettype none

module motor_pwm_ramp_with_reversal_core #(
	parameter int SPEED_FRAC_BITS = mpwm_pkg::SPEED_FRAC_BITS_DEF,
	parameter int DUTY_BITS       = mpwm_pkg::DUTY_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	mpwm_cmd_if.sink                             cmd,
	mpwm_res_if.source                           res,
	input  wire logic                            cfg_we,
	input  wire logic [mpwm_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [mpwm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mpwm_pkg::*;

	localparam int SW = SPEED_FRAC_BITS + 2;
	localparam int DW = DUTY_BITS;
	localparam int PW = SW + DW;
	localparam logic signed [SW-1:0] FULL_SCALE = SW'(1) <<< SPEED_FRAC_BITS;

	logic [DW-1:0]     pwm_max_q;
	logic [DW-1:0]     ramp_step_q;
	logic [DW-1:0]     rev_thr_q;
	logic [TICK_W-1:0] ramp_interval_q;

	logic              vld_s1;
	logic              op_s1;
	logic [SW-1:0]     spd_s1;

	logic [DW-1:0]     duty_now_q;
	logic [DW-1:0]     duty_goal_q;
	dir_t              dir_now_q;
	dir_t              dir_goal_q;
	logic [SW-1:0]     speed_goal_q;
	logic [TICK_W-1:0] tick_left_q;

	logic              ovld_q;
	logic [DW-1:0]     o_duty_q;
	dir_t              o_dir_q;
	logic              o_settled_q;
	logic              o_status_q;

	logic              advance;
	logic signed [SW-1:0] s_in;
	logic              spd_ok;
	dir_t              dir_in;
	logic [SW-1:0]     sg_n;
	logic [SW-1:0]     mag;
	logic [PW-1:0]     prod;
	logic [DW-1:0]     duty_tgt;
	logic [DW-1:0]     step;
	logic [DW:0]       up_sum;
	logic [DW-1:0]     ramped;
	logic [DW-1:0]     dn_mid;
	logic [DW-1:0]     dg_mid;
	dir_t              rg_mid;
	logic [DW-1:0]     duty_n;
	logic [DW-1:0]     goal_n;
	dir_t              dir_n;
	logic [TICK_W-1:0] tick_n;
	logic              changed;

	assign advance   = vld_s1 && (!ovld_q || res.ready);
	assign cmd.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_max_q       <= '1;
			ramp_step_q     <= DW'(RAMP_STEP_RST);
			rev_thr_q       <= '0;
			ramp_interval_q <= RAMP_INTERVAL_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_PWM_MAX:       pwm_max_q       <= cfg_data[DW-1:0];
				CFG_RAMP_STEP:     ramp_step_q     <= cfg_data[DW-1:0];
				CFG_REV_THRESHOLD: rev_thr_q       <= cfg_data[DW-1:0];
				CFG_RAMP_INTERVAL: ramp_interval_q <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			op_s1  <= cmd.opcode;
			spd_s1 <= cmd.speed;
		end
	end

	always_comb begin
		s_in   = signed'(spd_s1);
		spd_ok = (op_s1 == OP_SPEED) && (s_in <= FULL_SCALE) && (s_in >= -FULL_SCALE) &&
			(spd_s1 != speed_goal_q);
		if (s_in > 0) begin
			dir_in = DIR_FWD;
		end else if (s_in < 0) begin
			dir_in = DIR_REV;
		end else begin
			dir_in = DIR_NONE;
		end
		sg_n     = spd_ok ? spd_s1 : speed_goal_q;
		mag      = sg_n[SW-1] ? SW'(-signed'(sg_n)) : sg_n;
		prod     = PW'(pwm_max_q) * PW'(mag);
		duty_tgt = prod[SPEED_FRAC_BITS +: DW];

		step   = (ramp_step_q == '0) ? DW'(1) : ramp_step_q;
		up_sum = {1'b0, duty_now_q} + {1'b0, step};
		if (duty_now_q < duty_goal_q) begin
			ramped = (up_sum > {1'b0, duty_goal_q}) ? duty_goal_q : up_sum[DW-1:0];
		end else begin
			ramped = ((duty_now_q - duty_goal_q) < step) ? duty_goal_q : duty_now_q - step;
		end

		dn_mid = duty_now_q;
		dg_mid = duty_goal_q;
		rg_mid = dir_goal_q;
		tick_n = tick_left_q;
		if (op_s1 == OP_SPEED) begin
			if (spd_ok) begin
				rg_mid = dir_in;
				if (dir_in == dir_now_q) begin
					dg_mid = duty_tgt;
				end else if (duty_now_q > rev_thr_q) begin
					dg_mid = '0;
				end
			end
		end else if (tick_left_q != '0) begin
			tick_n = tick_left_q - TICK_W'(1);
		end else if (duty_now_q != duty_goal_q) begin
			dn_mid = ramped;
			tick_n = (ramp_interval_q == '0) ? '0 : ramp_interval_q - TICK_W'(1);
		end

		duty_n = dn_mid;
		goal_n = dg_mid;
		dir_n  = dir_now_q;
		if (dir_now_q != rg_mid && dn_mid <= rev_thr_q) begin
			dir_n  = rg_mid;
			goal_n = duty_tgt;
		end

		changed = (duty_n != duty_now_q) || (goal_n != duty_goal_q) ||
			(dir_n != dir_now_q) || (rg_mid != dir_goal_q) || spd_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_now_q   <= '0;
			duty_goal_q  <= '0;
			dir_now_q    <= DIR_NONE;
			dir_goal_q   <= DIR_NONE;
			speed_goal_q <= '0;
			tick_left_q  <= '0;
		end else if (advance) begin
			duty_now_q   <= duty_n;
			duty_goal_q  <= goal_n;
			dir_now_q    <= dir_n;
			dir_goal_q   <= rg_mid;
			speed_goal_q <= sg_n;
			tick_left_q  <= tick_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (advance) begin
			ovld_q <= 1'b1;
		end else if (res.ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			o_duty_q    <= duty_n;
			o_dir_q     <= dir_n;
			o_settled_q <= (duty_n == goal_n) && (dir_n == rg_mid);
			o_status_q  <= !changed;
		end
	end

	assign res.valid       = ovld_q;
	assign res.pwm_duty    = o_duty_q;
	assign res.reverse_pin = (o_dir_q == DIR_REV);
	assign res.direction   = o_dir_q;
	assign res.settled     = o_settled_q;
	assign res.status      = o_status_q;

`ifndef SYNTHESIS
	a_flip_low_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && dir_n != dir_now_q) |-> (duty_n <= rev_thr_q))
		else $error("direction flipped while duty above threshold");

	a_duty_on_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && duty_n != duty_now_q) |->
		(op_s1 == OP_TICK && tick_left_q == '0))
		else $error("duty moved outside a ramp step");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !advance) |=> (vld_s1 && $stable(spd_s1) && $stable(op_s1)))
		else $error("stalled command lost");

	a_result_after_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> ovld_q)
		else $error("result word not presented");
`endif

endmodule

`default_nettype wire
